// ----- rtl/sha_pkg.sv -----
package sha_pkg;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_FINISH = 1'b1
  } req_t;

  typedef logic [7:0][31:0] chain_t;

  typedef struct packed {
    logic       load;
    logic [7:0] byte_val;
    logic       start;
    logic       init;
  } core_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam chain_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- rtl/sha_core.sv -----
module sha_core
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  core_cmd_t cmd,
  output logic      busy,
  output chain_t    chain
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } cstate_t;

  cstate_t      state;
  logic [511:0] blk;
  chain_t       v;
  chain_t       v_next;
  logic [5:0]   rnd;
  logic [31:0]  w0, w1, w9, w14;
  logic [31:0]  new_w;
  logic [31:0]  t1, t2;

  // The message register doubles as the rolling schedule: word zero sits on top.
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];
  assign new_w = w0 + small_sig0(w1) + w9 + small_sig1(w14);

  always_comb begin
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[rnd] + w0;
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

  assign busy = (state != C_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      chain <= H_INIT;
      rnd   <= '0;
    end else begin
      if (cmd.init) begin
        chain <= H_INIT;
      end
      if (cmd.load) begin
        blk <= {blk[503:0], cmd.byte_val};
      end
      unique case (state)
        C_IDLE: begin
          if (cmd.start) begin
            v     <= chain;
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          v   <= v_next;
          blk <= {blk[479:0], new_w};
          rnd <= rnd + 6'd1;
          if (rnd == LAST_POS) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int j = 0; j < 8; j++) begin
            chain[j] <= chain[j] + v[j];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// SHA-256 hasher that takes the message one byte per word and returns the digest as eight
// 32-bit big-endian words, H0 first, with digest_last on the eighth. An append word that
// completes a 64-byte block holds the input stalled while the single round unit runs 64
// rounds and folds the result into the chaining words; other append words are taken with no
// stall. A finish word pads one byte per cycle while no block is being compressed (up to 64
// bytes), runs one or two such compressions, then offers the eight digest words one per cycle
// as the output side takes them; no new word is accepted until the last digest word is taken,
// after which the block starts the next message from the initial hash values.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [0:0]  req_type,
  input  logic [7:0]  data_byte,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_WAIT_DATA,
    S_WAIT_PAD,
    S_WAIT_FINAL,
    S_EMIT
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic        accept;
  logic        out_take;
  logic        core_busy;
  chain_t      chain;
  core_cmd_t   cmd;

  assign data_stall  = (state != S_IDLE);
  assign accept      = data_valid && !data_stall;
  assign out_take    = digest_valid && !digest_stall;
  assign digest_last = (word_index == LAST_WORD);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load     = 1'b1;
          cmd.byte_val = (req_type == REQ_FINISH) ? PAD_BYTE : data_byte;
          cmd.start    = (fill == LAST_POS);
        end
      end
      S_PAD: begin
        if (fill != LEN_POS) begin
          cmd.load  = 1'b1;
          cmd.start = (fill == LAST_POS);
        end
      end
      S_LEN: begin
        cmd.load     = 1'b1;
        cmd.byte_val = bit_length[63:56];
        cmd.start    = (fill == LAST_POS);
      end
      S_EMIT: begin
        cmd.init = out_take && digest_last;
      end
      S_WAIT_DATA, S_WAIT_PAD, S_WAIT_FINAL: begin
        cmd = '0;
      end
      default: cmd = '0;
    endcase
  end

  sha_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .busy  (core_busy),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      bit_length   <= '0;
      digest_valid <= 1'b0;
      word_index   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= fill + 6'd1;
            if (req_type == REQ_FINISH) begin
              bit_length <= bit_length + {55'd0, fill, 3'd0};
              state      <= (fill == LAST_POS) ? S_WAIT_PAD : S_PAD;
            end else if (fill == LAST_POS) begin
              bit_length <= bit_length + BLOCK_BITS;
              state      <= S_WAIT_DATA;
            end
          end
        end
        S_PAD: begin
          if (fill == LEN_POS) begin
            state <= S_LEN;
          end else begin
            fill <= fill + 6'd1;
            if (fill == LAST_POS) begin
              state <= S_WAIT_PAD;
            end
          end
        end
        S_LEN: begin
          fill       <= fill + 6'd1;
          bit_length <= {bit_length[55:0], 8'h00};
          if (fill == LAST_POS) begin
            state <= S_WAIT_FINAL;
          end
        end
        S_WAIT_DATA: begin
          if (!core_busy) begin
            state <= S_IDLE;
          end
        end
        S_WAIT_PAD: begin
          if (!core_busy) begin
            state <= S_PAD;
          end
        end
        S_WAIT_FINAL: begin
          if (!core_busy) begin
            state        <= S_EMIT;
            digest_valid <= 1'b1;
            digest_word  <= chain[0];
            word_index   <= '0;
          end
        end
        S_EMIT: begin
          if (out_take) begin
            if (digest_last) begin
              digest_valid <= 1'b0;
              fill         <= '0;
              bit_length   <= '0;
              state        <= S_IDLE;
            end else begin
              word_index  <= word_index + 3'd1;
              digest_word <= chain[word_index + 3'd1];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A byte is never taken while the round unit is compressing a block.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !core_busy)
    else $error("word accepted while compression is running");

  // Every compression starts on a block boundary.
  a_start_aligned: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (fill == 6'd0))
    else $error("compression started off a block boundary");

  // The round unit is busy for the cycle after a start.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> core_busy)
    else $error("compression did not start");

  // After the last digest word the message state is back at its start.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (out_take && digest_last) |=> (fill == 6'd0 && bit_length == 64'd0 && !digest_valid))
    else $error("message state not cleared after digest");

endmodule

// ----- sim/sha256_digest_checker.sv -----
`timescale 1ns / 1ps

module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_stall,
  input  logic [0:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic        digest_valid,
  input  logic        digest_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        digest_last,
  output int          error_count,
  output int          pending,
  output int          words_checked,
  output int          messages
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  digest_exp_t digest_q [$];

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] msg_bits;

  int err_cnt;
  int word_cnt;
  int msg_cnt;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    fill = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t - 15], 7) ^ ror32(w[t - 15], 18) ^ (w[t - 15] >> 3);
      s1 = ror32(w[t - 2], 17) ^ ror32(w[t - 2], 19) ^ (w[t - 2] >> 10);
      w[t] = w[t - 16] + s0 + w[t - 7] + s1;
    end
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int t = 0; t < 64; t++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] = chain[j] + v[j];
  endfunction

  function automatic void finish_message();
    logic [63:0] total;
    logic [5:0]  pos;
    digest_exp_t item;
    pos = fill;
    blk[pos] = PAD_BYTE;
    for (int i = int'(pos) + 1; i < 64; i++) blk[i] = 8'h00;
    // With no room left for the length, the padding spills into a second block.
    if (pos >= LEN_POS) begin
      compress_block();
      for (int i = 0; i < 56; i++) blk[i] = 8'h00;
    end
    total = msg_bits + {55'd0, pos, 3'd0};
    for (int i = 0; i < 8; i++) blk[56 + i] = total[63 - 8 * i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      item.word = chain[i];
      item.idx  = 3'(i);
      item.last = (3'(i) == LAST_WORD);
      digest_q.push_back(item);
    end
    restart_message();
  endfunction

  always @(posedge clk) begin
    digest_exp_t exp_item;
    if (rst) begin
      restart_message();
      digest_q.delete();
      err_cnt = 0;
      word_cnt = 0;
      msg_cnt = 0;
    end else begin
      if (data_valid && !data_stall) begin
        if (req_type == REQ_FINISH) begin
          finish_message();
          msg_cnt++;
        end else begin
          blk[fill] = data_byte;
          fill = fill + 6'd1;
          if (fill == 6'd0) begin
            compress_block();
            msg_bits = msg_bits + BLOCK_BITS;
          end
        end
      end
      if (digest_valid === 1'b1 && !digest_stall) begin
        word_cnt++;
        if (digest_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected digest word: expected none, actual %h index %0d last %0b",
                   $time, digest_word, word_index, digest_last);
        end else begin
          exp_item = digest_q.pop_front();
          if (digest_word !== exp_item.word) begin
            err_cnt++;
            $display("%0t: digest_word mismatch: expected %h, actual %h",
                     $time, exp_item.word, digest_word);
          end
          if (word_index !== exp_item.idx) begin
            err_cnt++;
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, exp_item.idx, word_index);
          end
          if (digest_last !== exp_item.last) begin
            err_cnt++;
            $display("%0t: digest_last mismatch: expected %0b, actual %0b",
                     $time, exp_item.last, digest_last);
          end
        end
      end
    end
    error_count   <= err_cnt;
    pending       <= digest_q.size();
    words_checked <= word_cnt;
    messages      <= msg_cnt;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sha_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_WORDS = 48;
  localparam int WORD_TARGET = 250;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [0:0]  req_type = REQ_APPEND;
  logic [7:0]  data_byte = 8'h00;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  int error_count;
  int pending;
  int words_checked;
  int messages;

  int burst_left = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  sha256_byte_stream_hasher u_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .digest_last  (digest_last)
  );

  sha256_digest_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .digest_valid  (digest_valid),
    .digest_stall  (digest_stall),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .digest_last   (digest_last),
    .error_count   (error_count),
    .pending       (pending),
    .words_checked (words_checked),
    .messages      (messages)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (digest_valid === 1'b1 && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls at a rate that changes from stretch to stretch, and
  // once holds off long enough for the hasher to back up into its input.
  initial begin
    int stall_pct;
    int phase_left;
    int hold_left;
    bit held;
    stall_pct = 0;
    phase_left = 30;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        digest_stall <= 1'b1;
      end else if (!held && words_checked >= HOLD_AFTER_WORDS) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        digest_stall <= 1'b1;
      end else begin
        phase_left--;
        if (phase_left <= 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
          phase_left = $urandom_range(20, 120);
        end
        digest_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic send_word(input req_t kind, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        data_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    @(negedge clk);
    data_valid <= 1'b1;
    req_type   <= kind;
    data_byte  <= value;
    do @(posedge clk); while (data_stall);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_word(REQ_APPEND, 8'($urandom_range(0, 255)));
    send_word(REQ_FINISH, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int edge_lens [8];
    int pick;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message, the byte extremes, a short text, and back-to-back finishes.
    send_word(REQ_FINISH, 8'h00);
    send_word(REQ_APPEND, 8'h00);
    send_word(REQ_FINISH, 8'hff);
    send_word(REQ_APPEND, 8'hff);
    send_word(REQ_FINISH, 8'h00);
    send_word(REQ_APPEND, 8'h61);
    send_word(REQ_APPEND, 8'h62);
    send_word(REQ_APPEND, 8'h63);
    send_word(REQ_FINISH, 8'h5a);
    send_word(REQ_FINISH, 8'ha5);

    while (words_sent < WORD_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) send_message(edge_lens[$urandom_range(0, 7)]);
      else if (pick == 2) send_message(0);
      else send_message($urandom_range(1, 24));
    end

    @(negedge clk);
    data_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);

    $display("Sent %0d input words in %0d messages; %0d digest words compared.",
             words_sent, messages, words_checked);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sha256_byte_stream_hasher.f -----
rtl/sha_pkg.sv
rtl/sha_core.sv
rtl/sha256_byte_stream_hasher.sv
sim/sha256_digest_checker.sv
sim/tb_top.sv
